// ----- design/cxpc_pkg.sv -----
// shared types, codes and constants of the chained xor packet cipher
package cxpc_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned IN_DATA_W     = 24;
  localparam int unsigned QUEUE_DEPTH   = 4;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_HDR_ENC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HDR_DEC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PAYLOAD = 2'd2;

  typedef enum logic [1:0] {
    OP_HDR_ENC = 2'd0,
    OP_HDR_DEC = 2'd1,
    OP_PAYLOAD = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BYTE_W-1:0] rand_key;
    logic [BYTE_W-1:0] check_byte;
    logic [BYTE_W-1:0] data_byte;
    logic             last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- design/chained_xor_packet_cipher_unit.sv -----
// top level of the chained xor packet cipher: front end, item queue, back end
// a result leaves the back end output register after its item has passed the queue
// throughput: one item per cycle unless the output stalls, set by the back end
// the queue absorbs up to QDEPTH items while the output side stalls
// unused command code 3 is accepted and swallowed without a result
// reset (rst_n low, synchronous): queue empty, output idle, key and all chain state zero
module chained_xor_packet_cipher_unit #(
  parameter int unsigned QDEPTH = cxpc_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration: fixed key byte
  input  logic                                cfg_wr_en,
  input  logic [cxpc_pkg::BYTE_W-1:0]         cfg_wr_data,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cxpc_pkg::IN_DATA_W-1:0]      in_tdata,  // rand_key, check_byte, data_byte
  input  logic [cxpc_pkg::CMD_W-1:0]          in_tuser,  // cmd
  input  logic                                in_tlast,  // final_byte
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cxpc_pkg::BYTE_W-1:0]         out_tdata, // out_byte
  output logic                                out_tuser, // check_ok
  output logic                                out_tlast  // end_of_packet
);

  // front to queue
  logic              push;
  cxpc_pkg::item_t   push_item;
  // queue to back
  logic              pop;
  cxpc_pkg::item_t   pop_item;
  cxpc_pkg::q_stat_t q_stat;

  // front end decodes the command and only forwards known items
  cxpc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // short queue lets the input keep flowing while the output stalls
  cxpc_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // back end holds the chaining state and the output register
  cxpc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .pop_item    (pop_item),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// ----- design/cxpc_front.sv -----
// front end: takes items from the input channel, decodes the command, drops unused codes
module cxpc_front (
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [cxpc_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic [cxpc_pkg::CMD_W-1:0]            in_tuser,
  input  logic                                  in_tlast,
  input  cxpc_pkg::q_stat_t                     q_stat,
  output logic                                  push,
  output cxpc_pkg::item_t                       push_item
);

  logic     known;
  cxpc_pkg::op_t op;

  always_comb begin
    known = 1'b1;
    op    = cxpc_pkg::OP_PAYLOAD;
    case (in_tuser)
      cxpc_pkg::CMD_HDR_ENC: op = cxpc_pkg::OP_HDR_ENC;
      cxpc_pkg::CMD_HDR_DEC: op = cxpc_pkg::OP_HDR_DEC;
      cxpc_pkg::CMD_PAYLOAD: op = cxpc_pkg::OP_PAYLOAD;
      default:               known = 1'b0;  // unused code, swallowed
    endcase
  end

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full && known;

  assign push_item.op         = op;
  assign push_item.rand_key   = in_tdata[7:0];
  assign push_item.check_byte = in_tdata[15:8];
  assign push_item.data_byte  = in_tdata[23:16];
  assign push_item.last       = in_tlast;

endmodule

// ----- design/cxpc_queue.sv -----
// short item queue between front and back end
module cxpc_queue #(
  parameter int unsigned QDEPTH = cxpc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cxpc_pkg::item_t   push_item,
  input  logic              pop,
  output cxpc_pkg::item_t   pop_item,
  output cxpc_pkg::q_stat_t q_stat
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QDEPTH);

  cxpc_pkg::item_t  slot_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item     = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);

endmodule

// ----- design/cxpc_back.sv -----
// back end: chained two-key xor, checksum tracking and the output register
module cxpc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cxpc_pkg::BYTE_W-1:0]   cfg_wr_data,
  input  cxpc_pkg::q_stat_t             q_stat,
  input  cxpc_pkg::item_t               pop_item,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cxpc_pkg::BYTE_W-1:0]   out_tdata,
  output logic                          out_tuser,
  output logic                          out_tlast
);

  localparam int unsigned BW = cxpc_pkg::BYTE_W;

  logic [BW-1:0] fixed_key_r;
  logic          decode_mode_r, decode_mode_nxt;
  logic [BW-1:0] packet_key_r, packet_key_nxt;
  logic [BW-1:0] prev_inner_r, prev_inner_nxt;
  logic [BW-1:0] prev_outer_r, prev_outer_nxt;
  logic [BW-1:0] byte_index_r, byte_index_nxt;
  logic [BW-1:0] plain_sum_r, plain_sum_nxt;
  logic [BW-1:0] expected_sum_r, expected_sum_nxt;

  logic          out_valid_r;
  logic [BW-1:0] out_byte_r, out_byte_nxt;
  logic          check_ok_r, check_ok_nxt;
  logic          eop_r;

  logic [BW-1:0] step, key_a, key_b, stage_a, stage_b;

  assign pop = !q_stat.empty && (!out_valid_r || out_tready);

  always_comb begin
    decode_mode_nxt  = decode_mode_r;
    packet_key_nxt   = packet_key_r;
    prev_inner_nxt   = prev_inner_r;
    prev_outer_nxt   = prev_outer_r;
    byte_index_nxt   = byte_index_r;
    plain_sum_nxt    = plain_sum_r;
    expected_sum_nxt = expected_sum_r;
    check_ok_nxt     = 1'b1;
    step             = byte_index_r + BW'(2);
    key_a            = '0;
    key_b            = '0;
    stage_a          = '0;
    stage_b          = '0;
    case (pop_item.op)
      cxpc_pkg::OP_HDR_ENC: begin
        key_a           = pop_item.rand_key + BW'(1);
        key_b           = fixed_key_r + BW'(1);
        stage_a         = pop_item.check_byte ^ key_a;
        stage_b         = stage_a ^ key_b;
        decode_mode_nxt = 1'b0;
        packet_key_nxt  = pop_item.rand_key;
        prev_inner_nxt  = stage_a;
        prev_outer_nxt  = stage_b;
        byte_index_nxt  = '0;
        plain_sum_nxt   = '0;
      end
      cxpc_pkg::OP_HDR_DEC: begin
        key_a            = fixed_key_r + BW'(1);
        key_b            = pop_item.rand_key + BW'(1);
        stage_a          = pop_item.check_byte ^ key_a;
        stage_b          = stage_a ^ key_b;
        decode_mode_nxt  = 1'b1;
        packet_key_nxt   = pop_item.rand_key;
        prev_inner_nxt   = stage_a;
        prev_outer_nxt   = pop_item.check_byte;
        byte_index_nxt   = '0;
        plain_sum_nxt    = '0;
        expected_sum_nxt = stage_b;
        // empty payload: sum is zero
        if (pop_item.last) begin
          check_ok_nxt = (stage_b == '0);
        end
      end
      cxpc_pkg::OP_PAYLOAD: begin
        if (!decode_mode_r) begin
          key_a          = packet_key_r + prev_inner_r + step;
          stage_a        = pop_item.data_byte ^ key_a;
          key_b          = fixed_key_r + prev_outer_r + step;
          stage_b        = stage_a ^ key_b;
          prev_inner_nxt = stage_a;
          prev_outer_nxt = stage_b;
        end else begin
          key_a          = prev_outer_r + fixed_key_r + step;
          stage_a        = pop_item.data_byte ^ key_a;
          key_b          = prev_inner_r + packet_key_r + step;
          stage_b        = stage_a ^ key_b;
          prev_outer_nxt = pop_item.data_byte;
          prev_inner_nxt = stage_a;
          plain_sum_nxt  = plain_sum_r + stage_b;
          if (pop_item.last) begin
            check_ok_nxt = (plain_sum_nxt == expected_sum_r);
          end
        end
        byte_index_nxt = byte_index_r + BW'(1);
      end
      default: begin
        stage_b = '0;
      end
    endcase
    out_byte_nxt = stage_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_key_r    <= '0;
      decode_mode_r  <= 1'b0;
      packet_key_r   <= '0;
      prev_inner_r   <= '0;
      prev_outer_r   <= '0;
      byte_index_r   <= '0;
      plain_sum_r    <= '0;
      expected_sum_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fixed_key_r <= cfg_wr_data;
      end
      if (pop) begin
        decode_mode_r  <= decode_mode_nxt;
        packet_key_r   <= packet_key_nxt;
        prev_inner_r   <= prev_inner_nxt;
        prev_outer_r   <= prev_outer_nxt;
        byte_index_r   <= byte_index_nxt;
        plain_sum_r    <= plain_sum_nxt;
        expected_sum_r <= expected_sum_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r <= out_byte_nxt;
      check_ok_r <= check_ok_nxt;
      eop_r      <= pop_item.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = check_ok_r;
  assign out_tlast  = eop_r;

endmodule

// ----- verif/chained_xor_packet_cipher_unit_tb.sv -----
// self-checking testbench of the chained xor packet cipher unit
module chained_xor_packet_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BW = cxpc_pkg::BYTE_W;
  localparam int unsigned CW = cxpc_pkg::CMD_W;

  // command code 3 is accepted and dropped without a result
  localparam logic [CW-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 110;
  localparam int LONG_PACKET = 258;  // long enough to wrap the byte index
  localparam int STALL_CYCLES = 64;
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic [CW-1:0] cmd;
    logic [BW-1:0] rk;
    logic [BW-1:0] cb;
    logic [BW-1:0] db;
    logic          fin;
  } stim_t;

  typedef struct packed {
    logic [BW-1:0] data;
    logic          ok;
    logic          eop;
  } cipher_result_t;

  typedef struct packed {
    logic          decode;
    logic [BW-1:0] pkt_key;
    logic [BW-1:0] chain_in;
    logic [BW-1:0] chain_out;
    logic [BW-1:0] idx;
    logic [BW-1:0] plain_sum;
    logic [BW-1:0] want_sum;
  } cipher_state_t;

  // item fields, then whether the result is typed in, its byte and its check flag
  typedef struct packed {
    logic [CW-1:0] cmd;
    logic [BW-1:0] rk;
    logic [BW-1:0] cb;
    logic [BW-1:0] db;
    logic          fin;
    logic          typed;
    logic [BW-1:0] exp_byte;
    logic          exp_ok;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 17;
  // fixed key is 0 throughout this table
  localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    // payload straight after reset: both chains and keys at zero
    '{cxpc_pkg::CMD_PAYLOAD, 8'hFF, 8'h00, 8'hA5, 1'b0, 1'b1, 8'hA5, 1'b1},
    // unused command, all ones, dropped
    '{CMD_UNUSED,            8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{cxpc_pkg::CMD_HDR_ENC, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1, 8'h01, 1'b1},
    '{cxpc_pkg::CMD_PAYLOAD, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{cxpc_pkg::CMD_PAYLOAD, 8'h55, 8'hAA, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    // payload after the packet has ended carries on the chains
    '{cxpc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0},
    // empty decode packets: checksum mismatch, then match
    '{cxpc_pkg::CMD_HDR_DEC, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b0},
    '{cxpc_pkg::CMD_HDR_DEC, 8'hFF, 8'h01, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b1},
    // empty encode packet
    '{cxpc_pkg::CMD_HDR_ENC, 8'h00, 8'h80, 8'h00, 1'b1, 1'b1, 8'h80, 1'b1},
    '{cxpc_pkg::CMD_HDR_DEC, 8'h12, 8'h34, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{cxpc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{cxpc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{CMD_UNUSED,            8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    // decode payload after the final item keeps summing
    '{cxpc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h77, 1'b1, 1'b0, 8'h00, 1'b0},
    '{cxpc_pkg::CMD_HDR_ENC, 8'h7F, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{cxpc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
    '{cxpc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h01, 1'b1, 1'b0, 8'h00, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [BW-1:0] cfg_wr_data;
  logic in_tvalid;
  logic in_tready;
  logic [cxpc_pkg::IN_DATA_W-1:0] in_tdata;
  logic [CW-1:0] in_tuser;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [BW-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  cipher_state_t cipher_st = '0;
  logic [BW-1:0] fixed_key_now = '0;
  cipher_result_t pending_results[$];
  int items_sent = 0;
  int mismatch_count = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  bit stall_wanted = 1'b0;

  chained_xor_packet_cipher_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),   // rand_key, check_byte, data_byte
    .in_tuser    (in_tuser),   // cmd
    .in_tlast    (in_tlast),   // final_byte
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),  // out_byte
    .out_tuser   (out_tuser),  // check_ok
    .out_tlast   (out_tlast)   // end_of_packet
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [BW-1:0] rand_byte();
    return BW'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  // one step of the cipher; returns 0 when the item yields no result
  function automatic bit cipher_step(inout cipher_state_t st, input logic [BW-1:0] fkey,
                                     input stim_t s, output cipher_result_t r);
    logic [BW-1:0] inner;
    logic [BW-1:0] plain;
    logic [BW-1:0] step;
    r.data = '0;
    r.ok = 1'b1;
    r.eop = s.fin;
    if (s.cmd == CMD_UNUSED) return 1'b0;
    case (s.cmd)
      cxpc_pkg::CMD_HDR_ENC: begin
        inner = s.cb ^ (s.rk + 8'd1);
        r.data = inner ^ (fkey + 8'd1);
        st.decode = 1'b0;
        st.pkt_key = s.rk;
        st.chain_in = inner;
        st.chain_out = r.data;
        st.idx = '0;
        st.plain_sum = '0;
      end
      cxpc_pkg::CMD_HDR_DEC: begin
        inner = s.cb ^ (fkey + 8'd1);
        plain = inner ^ (s.rk + 8'd1);
        st.decode = 1'b1;
        st.pkt_key = s.rk;
        st.chain_in = inner;
        st.chain_out = s.cb;
        st.idx = '0;
        st.plain_sum = '0;
        st.want_sum = plain;
        r.data = plain;
        if (s.fin) r.ok = (st.plain_sum == st.want_sum);
      end
      default: begin
        step = st.idx + 8'd2;
        if (!st.decode) begin
          inner = s.db ^ (st.pkt_key + st.chain_in + step);
          r.data = inner ^ (fkey + st.chain_out + step);
          st.chain_in = inner;
          st.chain_out = r.data;
        end else begin
          inner = s.db ^ (st.chain_out + fkey + step);
          plain = inner ^ (st.chain_in + st.pkt_key + step);
          st.chain_out = s.db;
          st.chain_in = inner;
          st.plain_sum = st.plain_sum + plain;
          r.data = plain;
          if (s.fin) r.ok = (st.plain_sum == st.want_sum);
        end
        st.idx = st.idx + 8'd1;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic stim_t make_item(input logic [CW-1:0] cmd, input logic [BW-1:0] rk,
                                      input logic [BW-1:0] cb, input logic [BW-1:0] db,
                                      input logic fin);
    stim_t s;
    s.cmd = cmd;
    s.rk = rk;
    s.cb = cb;
    s.db = db;
    s.fin = fin;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [BW-1:0] got,
                                 input logic [BW-1:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // offer one item with random gaps; the expectation is logged on acceptance
  task automatic send_item(input stim_t s, input bit use_typed, input cipher_result_t typed_r);
    cipher_result_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {s.db, s.cb, s.rk};
    in_tuser <= s.cmd;
    in_tlast <= s.fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cipher_step(cipher_st, fixed_key_now, s, r)) begin
      if (use_typed) r = typed_r;
      pending_results = {pending_results, r};
      items_sent++;
    end
  endtask

  task automatic send_plain(input stim_t s);
    send_item(s, 1'b0, '0);
  endtask

  // encode a random plaintext, then decode what came out, optionally with one bit flipped
  task automatic send_round_trip(input int len, input bit corrupt);
    logic [BW-1:0] plain_q[$];
    logic [BW-1:0] enc_q[$];
    cipher_state_t scratch;
    cipher_result_t r;
    stim_t s;
    logic [BW-1:0] key;
    logic [BW-1:0] sum;
    logic [BW-1:0] enc_hdr;
    logic [BW-1:0] b;
    int bad_at;
    int i;
    scratch = '0;
    key = rand_byte();
    sum = '0;
    for (i = 0; i < len; i++) begin
      b = rand_byte();
      plain_q = {plain_q, b};
      sum = sum + b;
    end
    // the header restarts the encode chain, so a scratch copy predicts it
    s = make_item(cxpc_pkg::CMD_HDR_ENC, key, sum, rand_byte(), len == 0);
    void'(cipher_step(scratch, fixed_key_now, s, r));
    enc_hdr = r.data;
    send_plain(s);
    for (i = 0; i < len; i++) begin
      s = make_item(cxpc_pkg::CMD_PAYLOAD, rand_byte(), rand_byte(), plain_q[i], i == len - 1);
      void'(cipher_step(scratch, fixed_key_now, s, r));
      enc_q = {enc_q, r.data};
      send_plain(s);
    end
    bad_at = (corrupt && len > 0) ? int'($urandom_range(len - 1)) : -1;
    send_plain(make_item(cxpc_pkg::CMD_HDR_DEC, key, enc_hdr, rand_byte(), len == 0));
    for (i = 0; i < len; i++) begin
      b = enc_q[i];
      if (i == bad_at) b = b ^ (8'd1 << $urandom_range(7));
      send_plain(make_item(cxpc_pkg::CMD_PAYLOAD, rand_byte(), rand_byte(), b, i == len - 1));
    end
  endtask

  task automatic send_random_packet(input logic [CW-1:0] hdr_cmd, input int len);
    int i;
    send_plain(make_item(hdr_cmd, rand_byte(), rand_byte(), rand_byte(), len == 0));
    for (i = 0; i < len; i++)
      send_plain(make_item(cxpc_pkg::CMD_PAYLOAD, rand_byte(), rand_byte(), rand_byte(),
                           i == len - 1));
  endtask

  // let every expected result out, with the input held idle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (cxpc_pkg::QUEUE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_fixed_key(input logic [BW-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fixed_key_now = v;
  endtask

  // receiver: random back-pressure plus one long hold-off
  initial begin : result_sink
    int hold_left;
    bit stall_done;
    hold_left = 0;
    stall_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_wanted && !stall_done) begin
        stall_done = 1'b1;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    cipher_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata, 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.data) report_mismatch("out_byte", out_tdata, want.data);
        if (out_tuser !== want.ok)
          report_mismatch("check_ok", BW'(out_tuser), BW'(want.ok));
        if (out_tlast !== want.eop)
          report_mismatch("end_of_packet", BW'(out_tlast), BW'(want.eop));
      end
    end
  end

  initial begin : stimulus
    cipher_result_t typed_r;
    directed_row_t row;
    logic [BW-1:0] key;
    int target;
    int pick;
    int n;
    int i;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    in_tlast <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 24;
    rcv_idle_pct = 59;
    write_fixed_key(8'h00);
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED_TABLE[i];
      typed_r.data = row.exp_byte;
      typed_r.ok = row.exp_ok;
      typed_r.eop = row.fin;
      send_item(make_item(row.cmd, row.rk, row.cb, row.db, row.fin), row.typed, typed_r);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      // idle pattern: sender light, then receiver light, then none at all
      if (ph < 2) begin
        snd_idle_pct = 24;
        rcv_idle_pct = 59;
      end else if (ph < 4) begin
        snd_idle_pct = 59;
        rcv_idle_pct = 24;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (ph)
        0: key = 8'hFF;
        2: key = 8'h00;
        4: key = 8'h80;
        5: key = 8'h01;
        default: key = BW'($urandom_range(254, 1));
      endcase
      write_fixed_key(key);
      target = items_sent + PHASE_ITEMS;
      if (ph == 0) send_round_trip(LONG_PACKET, 1'b0);
      if (ph == 4) stall_wanted = 1'b1;
      while (items_sent < target) begin
        pick = int'($urandom_range(99));
        if (pick < 45) begin
          send_round_trip(int'($urandom_range(12)), $urandom_range(3) == 0);
        end else if (pick < 70) begin
          send_random_packet(cxpc_pkg::CMD_HDR_ENC, int'($urandom_range(16)));
        end else if (pick < 82) begin
          send_random_packet(cxpc_pkg::CMD_HDR_DEC, int'($urandom_range(8)));
        end else if (pick < 92) begin
          // stray payload outside a fresh packet
          n = int'($urandom_range(3, 1));
          for (i = 0; i < n; i++)
            send_plain(make_item(cxpc_pkg::CMD_PAYLOAD, rand_byte(), rand_byte(), rand_byte(),
                                 rand_bit()));
        end else begin
          // noise, unused command among it
          n = int'($urandom_range(3, 1));
          for (i = 0; i < n; i++)
            send_plain(make_item(CW'($urandom_range(3)), rand_byte(), rand_byte(), rand_byte(),
                                 rand_bit()));
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/cxpc_pkg.sv
design/cxpc_front.sv
design/cxpc_queue.sv
design/cxpc_back.sv
design/chained_xor_packet_cipher_unit.sv
verif/chained_xor_packet_cipher_unit_tb.sv
